>>> src/ile_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types, codes and defaults of the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 7;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD_BACK     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_FRONT    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TAKE_FRONT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TAKE_BACK    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE_AT    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_READ_AT      = 3'd6;
    localparam logic [CMD_W-1:0] CMD_REMOVE_VALUE = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  position;
        logic [ITEM_W-1:0] item_value;
        logic              wipe;
    } job_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ITEM_W-1:0]   read_word;
        logic [TOTAL_W-1:0]  entry_total;
        logic [ITEM_W-1:0]   front_word;
        logic [ITEM_W-1:0]   back_word;
    } result_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

endpackage

>>> src/ile_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ile_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/ile_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_seq
// Command sequencer: checks a command, then moves or scans entries one per
// cycle through the store's ports and gathers the front and back words.
// ----------------------------------------------------------------------------
module ile_seq
    import ile_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  job_t                        job,
    input  logic                        ack,
    output seq_stat_t                   stat,
    output result_t                     res,
    output logic                        ram_we,
    output logic [$clog2(CAPACITY)-1:0] ram_waddr,
    output logic [DATA_WIDTH-1:0]       ram_wdata,
    output logic                        ram_re,
    output logic [$clog2(CAPACITY)-1:0] ram_raddr,
    input  logic [DATA_WIDTH-1:0]       ram_rdata
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SHIFT = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_PLACE = 4'd3;
    localparam logic [3:0] S_RDAT  = 4'd4;
    localparam logic [3:0] S_RDCAP = 4'd5;
    localparam logic [3:0] S_FRONT = 4'd6;
    localparam logic [3:0] S_BACK  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         src_reg, src_next;
    logic [CW-1:0]         wr_reg, wr_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_idx_reg, pend_idx_next;
    logic                  match_reg, match_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    logic [DATA_WIDTH-1:0] read_reg, read_next;
    logic [DATA_WIDTH-1:0] front_reg, front_next;

    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    logic            full;
    logic            empty;
    logic            keep;

    assign pos_x = CMPW'(job.position);
    assign cnt_x = CMPW'(count_reg);
    assign full  = (count_reg == CW'(CAPACITY));
    assign empty = (count_reg == '0);
    // shared compare: drop a scanned word that matches in remove-value mode
    assign keep  = !match_reg || (ram_rdata != word_reg);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        src_next      = src_reg;
        wr_next       = wr_reg;
        pos_next      = pos_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        match_next    = match_reg;
        status_next   = status_reg;
        word_next     = word_reg;
        read_next     = read_reg;
        front_next    = front_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    word_next   = DATA_WIDTH'(job.item_value);
                    status_next = ST_OK;
                    read_next   = '0;
                    pend_next   = 1'b0;
                    match_next  = 1'b0;
                    state_next  = empty ? S_FIN : S_FRONT;
                    if (job.wipe)
                    begin
                        count_next = '0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        unique case (job.cmd) inside
                            CMD_ADD_BACK, CMD_ADD_FRONT:
                            begin
                                if (full)
                                begin
                                    status_next = ST_FULL;
                                end
                                else
                                begin
                                    pos_next   = (job.cmd == CMD_ADD_BACK) ? count_reg : '0;
                                    src_next   = count_reg;
                                    state_next = S_SHIFT;
                                end
                            end
                            CMD_INSERT:
                            begin
                                if (pos_x > cnt_x)
                                begin
                                    status_next = ST_RANGE;
                                end
                                else if (full)
                                begin
                                    status_next = ST_FULL;
                                end
                                else
                                begin
                                    pos_next   = CW'(job.position);
                                    src_next   = count_reg;
                                    state_next = S_SHIFT;
                                end
                            end
                            CMD_TAKE_FRONT:
                            begin
                                if (empty)
                                begin
                                    status_next = ST_EMPTY;
                                end
                                else
                                begin
                                    src_next   = CW'(1);
                                    wr_next    = '0;
                                    state_next = S_SCAN;
                                end
                            end
                            CMD_TAKE_BACK:
                            begin
                                if (empty)
                                begin
                                    status_next = ST_EMPTY;
                                end
                                else
                                begin
                                    src_next   = count_reg;
                                    wr_next    = count_reg - CW'(1);
                                    state_next = S_SCAN;
                                end
                            end
                            CMD_REMOVE_AT, CMD_READ_AT:
                            begin
                                if (empty)
                                begin
                                    status_next = ST_EMPTY;
                                end
                                else if (pos_x >= cnt_x)
                                begin
                                    status_next = ST_RANGE;
                                end
                                else if (job.cmd == CMD_READ_AT)
                                begin
                                    pos_next   = CW'(job.position);
                                    state_next = S_RDAT;
                                end
                                else
                                begin
                                    src_next   = CW'(job.position) + CW'(1);
                                    wr_next    = CW'(job.position);
                                    state_next = S_SCAN;
                                end
                            end
                            CMD_REMOVE_VALUE:
                            begin
                                src_next   = '0;
                                wr_next    = '0;
                                match_next = 1'b1;
                                state_next = S_SCAN;
                            end
                        endcase
                    end
                end
            end

            S_SHIFT:
            begin
                // read descending, write each word one place toward the back
                if (src_reg != pos_reg)
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = AW'(src_reg - CW'(1));
                    src_next      = src_reg - CW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = AW'(src_reg - CW'(1));
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_idx_reg + AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (src_reg == pos_reg && !pend_reg)
                begin
                    state_next = S_PLACE;
                end
            end

            S_PLACE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(pos_reg);
                ram_wdata  = word_reg;
                count_next = count_reg + CW'(1);
                state_next = S_FRONT;
            end

            S_SCAN:
            begin
                // read ascending, write back the kept words packed to the front
                if (src_reg != count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(src_reg);
                    src_next  = src_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg && keep)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(wr_reg);
                    ram_wdata = ram_rdata;
                    wr_next   = wr_reg + CW'(1);
                end
                if (src_reg == count_reg && !pend_reg)
                begin
                    count_next = wr_reg;
                    state_next = (wr_reg == '0) ? S_FIN : S_FRONT;
                end
            end

            S_RDAT:
            begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(pos_reg);
                state_next = S_RDCAP;
            end

            S_RDCAP:
            begin
                read_next  = ram_rdata;
                state_next = S_FRONT;
            end

            S_FRONT:
            begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_next = S_BACK;
            end

            S_BACK:
            begin
                front_next = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = AW'(count_reg - CW'(1));
                state_next = S_FIN;
            end

            S_FIN:
            begin
                // back word stays on the read port until the result is taken
                if (ack)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        wr_reg       <= wr_next;
        pos_reg      <= pos_next;
        pend_idx_reg <= pend_idx_next;
        match_reg    <= match_next;
        status_reg   <= status_next;
        word_reg     <= word_next;
        read_reg     <= read_next;
        front_reg    <= front_next;
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_FIN);

    assign res.status      = status_reg;
    assign res.read_word   = ITEM_W'(read_reg);
    assign res.entry_total = TOTAL_W'(count_reg);
    assign res.front_word  = (count_reg == '0) ? '0 : ITEM_W'(front_reg);
    assign res.back_word   = (count_reg == '0) ? '0 : ITEM_W'(ram_rdata);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write hit the same entry");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_FIN) |-> !ram_we)
        else $error("store written outside a command");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == S_IDLE))
        else $error("command started while busy");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.done && !ack) |=> (stat.done && $stable(res)))
        else $error("finished result changed before it was taken");

endmodule

>>> src/indexed_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine
// Bounded ordered list of up to CAPACITY words with push, insert, pop,
// remove, read, remove-by-value and wipe commands, one result per command.
//
//   channel   | dir | tdata (low bit up)                           | tuser
//   ----------+-----+----------------------------------------------+---------------
//   s_axis    | in  | position[6:0], item_value[38:7], pad[39]     | cmd[2:0], wipe[3]
//   m_axis    | out | read_word[31:0], entry_total[38:32],         | status[1:0]
//             |     | front_word[70:39], back_word[102:71], pad    |
//
// Steps: after acceptance a command moves or scans its entries (push and
// insert then place the new word; read at reads its entry instead), then
// reads the front and back words before the output register is loaded; a
// refused command only reads them, and a wipe or a command that leaves the
// list empty skips them. The block is ready again in the cycle after the
// load. The store's single read port and single write port move one entry
// per cycle.
// Reset clears the state, the entry count and the output valid flag; the store needs no clearing pass.
// s_axis_tready is high only while no command is in flight. A finished
// result waits in the output register, so the next command can start while
// m_axis stalls; that command then holds in its last step until the
// register frees up.
// ----------------------------------------------------------------------------
module indexed_list_engine
    import ile_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // position, item_value, zero pad
    input  logic [3:0]   s_axis_tuser,   // cmd, wipe
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // read_word, entry_total, front_word,
                                         // back_word, zero pad
    output logic [1:0]   m_axis_tuser    // status
);

    localparam int AW = $clog2(CAPACITY);

    job_t      job;
    seq_stat_t stat;
    result_t   res;
    logic      start;
    logic      load;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;

    // unpack the incoming word
    assign job.cmd        = s_axis_tuser[2:0];
    assign job.wipe       = s_axis_tuser[3];
    assign job.position   = s_axis_tdata[6:0];
    assign job.item_value = s_axis_tdata[38:7];

    assign s_axis_tready = stat.idle;
    assign start         = s_axis_tvalid && s_axis_tready;

    // take the finished result once the output register is free or draining
    assign load = stat.done && (!out_valid_reg || m_axis_tready);

    ile_seq #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .job       (job),
        .ack       (load),
        .stat      (stat),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    ile_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register: advance on load, drop once the word is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = {1'b0,
                            out_res_reg.back_word,
                            out_res_reg.front_word,
                            out_res_reg.entry_total,
                            out_res_reg.read_word};

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed list engine. A shadow list computes the
// reply to every accepted command word, and each reply word is checked field
// by field against the oldest pending reply. Stimulus is a short directed
// pass over the empty, range and duplicate cases, then random fill, drain
// and mixed sequences under four sender/receiver pacing phases.
// ----------------------------------------------------------------------------
module tb_top;
    import ile_pkg::*;

    localparam int DEPTH       = CAPACITY_DEF;
    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 100;
    localparam int PHASE_ITEMS = 160;

    // ------------------------------------------------------------------------
    // Shadow list: mirrors the engine's entries and holds the pending replies.
    // ------------------------------------------------------------------------
    class list_mirror;
        logic [ITEM_W-1:0] slots [DEPTH];
        int unsigned       fill;
        result_t           pending_q [$];
        int unsigned       mismatches;
        int unsigned       checked;
        int unsigned       status_seen [4];
        int unsigned       peak;

        function new();
            fill       = 0;
            mismatches = 0;
            checked    = 0;
            peak       = 0;
        endfunction

        // open a gap at 'at' and drop the word in
        function void shift_in(int unsigned at, logic [ITEM_W-1:0] w);
            int unsigned i;
            for (i = fill; i > at; i--)
                slots[i] = slots[i - 1];
            slots[at] = w;
            fill++;
        endfunction

        // close the gap left by the entry at 'at'
        function void shift_out(int unsigned at);
            int unsigned i;
            for (i = at; i + 1 < fill; i++)
                slots[i] = slots[i + 1];
            fill--;
        endfunction

        function void note_command(job_t j);
            result_t             r;
            logic [STATUS_W-1:0] st;
            int unsigned         i;
            r  = '0;
            st = ST_OK;
            if (j.wipe) begin
                fill = 0;
            end
            else begin
                case (j.cmd)
                    CMD_ADD_BACK:
                        if (fill >= DEPTH) st = ST_FULL;
                        else shift_in(fill, j.item_value);
                    CMD_ADD_FRONT:
                        if (fill >= DEPTH) st = ST_FULL;
                        else shift_in(0, j.item_value);
                    CMD_INSERT:
                        // range is checked before fullness
                        if (j.position > fill) st = ST_RANGE;
                        else if (fill >= DEPTH) st = ST_FULL;
                        else shift_in(j.position, j.item_value);
                    CMD_TAKE_FRONT:
                        if (fill == 0) st = ST_EMPTY;
                        else shift_out(0);
                    CMD_TAKE_BACK:
                        if (fill == 0) st = ST_EMPTY;
                        else shift_out(fill - 1);
                    CMD_REMOVE_AT:
                        if (fill == 0) st = ST_EMPTY;
                        else if (j.position >= fill) st = ST_RANGE;
                        else shift_out(j.position);
                    CMD_READ_AT:
                        if (fill == 0) st = ST_EMPTY;
                        else if (j.position >= fill) st = ST_RANGE;
                        else r.read_word = slots[j.position];
                    default:
                    begin
                        // re-test the same index after a removal so that
                        // adjacent matches all go
                        i = 0;
                        while (i < fill) begin
                            if (slots[i] == j.item_value) shift_out(i);
                            else i++;
                        end
                    end
                endcase
            end
            r.status      = st;
            r.entry_total = fill[TOTAL_W-1:0];
            r.front_word  = (fill != 0) ? slots[0] : '0;
            r.back_word   = (fill != 0) ? slots[fill - 1] : '0;
            status_seen[st]++;
            if (fill > peak) peak = fill;
            pending_q.insert(pending_q.size(), r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] reply with none pending: st=%0d rd=%h n=%0d f=%h b=%h",
                             $realtime, got.status, got.read_word, got.entry_total,
                             got.front_word, got.back_word);
                return;
            end
            want = pending_q[0];
            pending_q.delete(0);
            checked++;
            if (got.status !== want.status || got.read_word !== want.read_word ||
                got.entry_total !== want.entry_total ||
                got.front_word !== want.front_word || got.back_word !== want.back_word) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] reply mismatch #%0d", $realtime, checked);
                    $display("    want st=%0d rd=%h n=%0d f=%h b=%h", want.status,
                             want.read_word, want.entry_total, want.front_word, want.back_word);
                    $display("    got  st=%0d rd=%h n=%0d f=%h b=%h", got.status,
                             got.read_word, got.entry_total, got.front_word, got.back_word);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata  = '0;   // position, item_value, zero pad
    logic [3:0]   s_axis_tuser  = '0;   // cmd, wipe
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;         // read_word, entry_total, front_word,
                                        // back_word, zero pad
    logic [1:0]   m_axis_tuser;         // status

    int unsigned  send_idle_pct  = 0;
    int unsigned  recv_stall_pct = 0;
    int unsigned  accepted_cmds  = 0;
    int unsigned  quiet_cycles   = 0;
    list_mirror   mirror;

    initial begin
        forever #10 clk = ~clk;
    end

    indexed_list_engine u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // receiver: stall at the configured rate, decided at each falling edge
    always @(negedge clk) begin
        m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // check reply words and watch for a hang
    always @(posedge clk) begin
        result_t got;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status      = m_axis_tuser;
                got.read_word   = m_axis_tdata[31:0];
                got.entry_total = m_axis_tdata[38:32];
                got.front_word  = m_axis_tdata[70:39];
                got.back_word   = m_axis_tdata[102:71];
                mirror.check_result(got);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] no handshake for %0d cycles, %0d replies pending",
                         $realtime, QUIET_LIMIT, mirror.pending_q.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // present one command word, idling first at the sender rate; hold valid
    // high from word to word when no idle cycle falls between them
    task automatic issue(input logic [CMD_W-1:0] cmd, input int unsigned pos,
                         input logic [ITEM_W-1:0] value, input logic wipe);
        job_t j;
        j.cmd        = cmd;
        j.position   = pos[POS_W-1:0];
        j.item_value = value;
        j.wipe       = wipe;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {1'b0, j.item_value, j.position};
        s_axis_tuser  = {j.wipe, j.cmd};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        mirror.note_command(j);
        accepted_cmds++;
    endtask

    // hold the sender off until every pending reply has come back
    task automatic drain_replies();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (mirror.pending_q.size() != 0) @(posedge clk);
    endtask

    // a few recurring words give remove-value something to match
    function automatic logic [ITEM_W-1:0] pick_value();
        logic [ITEM_W-1:0] pool [5];
        pool[0] = '0;
        pool[1] = '1;
        pool[2] = 32'h0000_0001;
        pool[3] = 32'h8000_0000;
        pool[4] = 32'h5A5A_C3C3;
        if ($urandom_range(0, 99) < 30) return pool[$urandom_range(0, 4)];
        return $urandom;
    endfunction

    // mostly in or just past the list, sometimes anywhere the field reaches
    function automatic int unsigned pick_position();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(0, mirror.fill);
        if (roll < 90) return $urandom_range(0, DEPTH);
        return $urandom_range(0, 127);
    endfunction

    // a word already in the list, or a fresh one when the list is empty and on one draw in five
    function automatic logic [ITEM_W-1:0] pick_stored();
        if (mirror.fill == 0 || $urandom_range(0, 99) < 20) return pick_value();
        return mirror.slots[$urandom_range(0, mirror.fill - 1)];
    endfunction

    task automatic run_directed();
        // wipe ignores cmd
        issue(CMD_ADD_BACK, 0, 32'hCAFE_0001, 1'b1);
        // every access on an empty list
        issue(CMD_TAKE_FRONT, 0, '0, 1'b0);
        issue(CMD_TAKE_BACK, 0, '0, 1'b0);
        issue(CMD_REMOVE_AT, 0, '0, 1'b0);
        issue(CMD_READ_AT, 0, '0, 1'b0);
        issue(CMD_REMOVE_VALUE, 0, '0, 1'b0);
        issue(CMD_INSERT, 1, 32'h1111_1111, 1'b0);
        // build [12345678, FFFFFFFF, 0, A5A5A5A5]
        issue(CMD_INSERT, 0, '1, 1'b0);
        issue(CMD_ADD_BACK, 0, '0, 1'b0);
        issue(CMD_ADD_FRONT, 127, 32'h1234_5678, 1'b0);
        issue(CMD_INSERT, 3, 32'hA5A5_A5A5, 1'b0);
        issue(CMD_READ_AT, 0, '0, 1'b0);
        issue(CMD_READ_AT, 3, '0, 1'b0);
        issue(CMD_READ_AT, 4, '0, 1'b0);
        issue(CMD_READ_AT, 127, '1, 1'b0);
        // adjacent duplicates, plus one at the front
        issue(CMD_ADD_BACK, 0, 32'h1234_5678, 1'b0);
        issue(CMD_ADD_BACK, 0, 32'h1234_5678, 1'b0);
        issue(CMD_REMOVE_VALUE, 0, 32'h1234_5678, 1'b0);
        issue(CMD_REMOVE_AT, 64, '0, 1'b0);
        issue(CMD_INSERT, 64, '1, 1'b0);
        issue(CMD_REMOVE_AT, 0, '0, 1'b0);
        issue(CMD_TAKE_BACK, 0, '0, 1'b0);
        issue(CMD_TAKE_FRONT, 0, '0, 1'b0);
        issue(CMD_ADD_BACK, 0, 32'h0F0F_0F0F, 1'b0);
        issue(CMD_REMOVE_VALUE, 127, '1, 1'b1);
    endtask

    // random fill, drain and mixed stretches until the budget is spent
    task automatic run_random_phase(input int unsigned budget);
        int unsigned sent;
        int unsigned roll;
        int unsigned k;
        int unsigned n;
        sent = 0;
        while (sent < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                // fill to capacity, then knock on the full list a few times
                while (mirror.fill < DEPTH) begin
                    case ($urandom_range(0, 2))
                        0: issue(CMD_ADD_BACK, $urandom_range(0, 127), pick_value(), 1'b0);
                        1: issue(CMD_ADD_FRONT, $urandom_range(0, 127), pick_value(), 1'b0);
                        default: issue(CMD_INSERT, pick_position(), pick_value(), 1'b0);
                    endcase
                    sent++;
                end
                n = $urandom_range(2, 4);
                for (k = 0; k < n; k++) begin
                    case ($urandom_range(0, 2))
                        0: issue(CMD_ADD_BACK, 0, pick_value(), 1'b0);
                        1: issue(CMD_ADD_FRONT, 0, pick_value(), 1'b0);
                        default: issue(CMD_INSERT, pick_position(), pick_value(), 1'b0);
                    endcase
                    sent++;
                end
            end
            else if (roll < 55) begin
                // drain to empty, then poke the empty list
                while (mirror.fill != 0) begin
                    case ($urandom_range(0, 4))
                        0: issue(CMD_TAKE_FRONT, 0, pick_value(), 1'b0);
                        1: issue(CMD_TAKE_BACK, 0, pick_value(), 1'b0);
                        2: issue(CMD_REMOVE_AT, $urandom_range(0, mirror.fill - 1),
                                 pick_value(), 1'b0);
                        3: issue(CMD_READ_AT, pick_position(), pick_value(), 1'b0);
                        default: issue(CMD_REMOVE_VALUE, 0, pick_stored(), 1'b0);
                    endcase
                    sent++;
                end
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++) begin
                    issue(CMD_W'(CMD_TAKE_FRONT + $urandom_range(0, 3)), pick_position(),
                          pick_value(), 1'b0);
                    sent++;
                end
            end
            else begin
                // mixed noise over every command, with the odd wipe
                n = $urandom_range(15, 40);
                for (k = 0; k < n; k++) begin
                    issue(CMD_W'($urandom_range(0, 7)), pick_position(),
                          ($urandom_range(0, 1) != 0) ? pick_stored() : pick_value(),
                          ($urandom_range(0, 99) < 3));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        mirror = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        drain_replies();

        // pacing phases: none, slow sender, slow receiver, light on both
        send_idle_pct = 0;  recv_stall_pct = 0;
        run_random_phase(PHASE_ITEMS);
        drain_replies();
        send_idle_pct = 81; recv_stall_pct = 0;
        run_random_phase(PHASE_ITEMS);
        drain_replies();
        send_idle_pct = 0;  recv_stall_pct = 81;
        run_random_phase(PHASE_ITEMS);
        drain_replies();
        send_idle_pct = 10; recv_stall_pct = 10;
        run_random_phase(PHASE_ITEMS);
        drain_replies();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d list commands over four pacing phases, %0d replies checked, %0d bad",
                 accepted_cmds, mirror.checked, mirror.mismatches);
        $display("Peak fill %0d of %0d; replies ok %0d, empty %0d, range %0d, full %0d",
                 mirror.peak, DEPTH, mirror.status_seen[ST_OK], mirror.status_seen[ST_EMPTY],
                 mirror.status_seen[ST_RANGE], mirror.status_seen[ST_FULL]);
        if (mirror.mismatches == 0 && mirror.pending_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
src/ile_pkg.sv
src/ile_ram.sv
src/ile_seq.sv
src/indexed_list_engine.sv
sim/tb_top.sv
